FILE: rtl/core/mp2d_pkg.sv
// Shared types, register indexes and a size-clamp helper for the 2-D max pooling block.
package mp2d_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int INDEX_BITS = 8;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS = 9;
  localparam int IMG_SIZE_BITS = 9;
  localparam int WIN_SIZE_BITS = 5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_ROWS  = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_COLS  = 4'd3;

  localparam logic [IMG_SIZE_BITS-1:0] RESET_IMAGE_WIDTH  = 9'd5;
  localparam logic [IMG_SIZE_BITS-1:0] RESET_IMAGE_HEIGHT = 9'd5;
  localparam logic [WIN_SIZE_BITS-1:0] RESET_WINDOW_ROWS  = 5'd3;
  localparam logic [WIN_SIZE_BITS-1:0] RESET_WINDOW_COLS  = 5'd3;

  // Per-pixel flags and output position, from the position tracker
  typedef struct packed {
    logic                  first;      // first pixel of its window
    logic                  emit;       // last pixel of its window
    logic                  frame_end;  // last pixel of the image
    logic [INDEX_BITS-1:0] out_row;
    logic [INDEX_BITS-1:0] out_col;
  } pos_info_t;

  // Zero reads as one, anything above the limit reads as the limit
  function automatic logic [IMG_SIZE_BITS-1:0] clamp_size(logic [IMG_SIZE_BITS-1:0] v,
                                                          int hi);
    logic [IMG_SIZE_BITS-1:0] r;
    if (v == '0) begin
      r = IMG_SIZE_BITS'(1);
    end else if (int'(v) > hi) begin
      r = IMG_SIZE_BITS'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/mp2d_pos.sv
// Raster position tracker: pixel, window and output counters.
module mp2d_pos #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WINDOW = 16,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int WW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic                          advance,
  input  logic [mp2d_pkg::IMG_SIZE_BITS-1:0] width,
  input  logic [mp2d_pkg::IMG_SIZE_BITS-1:0] height,
  input  logic [mp2d_pkg::WIN_SIZE_BITS-1:0] win_rows,
  input  logic [mp2d_pkg::WIN_SIZE_BITS-1:0] win_cols,
  output mp2d_pkg::pos_info_t           info,
  output logic [CW-1:0]                 slot
);
  import mp2d_pkg::*;

  logic [CW-1:0] pixel_col, pixel_col_next;
  logic [RW-1:0] pixel_row, pixel_row_next;
  logic [WW-1:0] row_in_band, row_in_band_next;
  logic [WW-1:0] col_in_window, col_in_window_next;
  logic [CW-1:0] pool_col, pool_col_next;
  logic [RW-1:0] pool_row, pool_row_next;

  logic last_col, last_row, win_col_full, win_row_full;

  assign last_col     = 32'(pixel_col) >= 32'(width) - 32'd1;
  assign last_row     = 32'(pixel_row) >= 32'(height) - 32'd1;
  assign win_col_full = 32'(col_in_window) >= 32'(win_cols) - 32'd1;
  assign win_row_full = 32'(row_in_band) >= 32'(win_rows) - 32'd1;

  assign slot           = pool_col;
  assign info.first     = (row_in_band == '0) && (col_in_window == '0);
  assign info.emit      = (last_col || win_col_full) && (last_row || win_row_full);
  assign info.frame_end = last_col && last_row;
  assign info.out_row   = INDEX_BITS'(pool_row);
  assign info.out_col   = INDEX_BITS'(pool_col);

  always_comb begin
    pixel_col_next     = pixel_col;
    pixel_row_next     = pixel_row;
    row_in_band_next   = row_in_band;
    col_in_window_next = col_in_window;
    pool_col_next      = pool_col;
    pool_row_next      = pool_row;
    if (last_col) begin
      pixel_col_next     = '0;
      col_in_window_next = '0;
      pool_col_next      = '0;
      if (last_row) begin
        pixel_row_next   = '0;
        row_in_band_next = '0;
        pool_row_next    = '0;
      end else begin
        pixel_row_next = pixel_row + RW'(1);
        if (win_row_full) begin
          row_in_band_next = '0;
          pool_row_next    = pool_row + RW'(1);
        end else begin
          row_in_band_next = row_in_band + WW'(1);
        end
      end
    end else begin
      pixel_col_next = pixel_col + CW'(1);
      if (win_col_full) begin
        col_in_window_next = '0;
        pool_col_next      = pool_col + CW'(1);
      end else begin
        col_in_window_next = col_in_window + WW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pixel_col     <= '0;
      pixel_row     <= '0;
      row_in_band   <= '0;
      col_in_window <= '0;
      pool_col      <= '0;
      pool_row      <= '0;
    end else if (advance) begin
      pixel_col     <= pixel_col_next;
      pixel_row     <= pixel_row_next;
      row_in_band   <= row_in_band_next;
      col_in_window <= col_in_window_next;
      pool_col      <= pool_col_next;
      pool_row      <= pool_row_next;
    end
  end

endmodule

FILE: rtl/core/max_pooling_2d_top.sv
// Non-overlapping 2-D max pooling over a raster pixel stream.
// Takes one signed pixel per clock in raster order, held off only by result back-pressure; a
// pooled result passes the input and then the result register, and m_axis_tlast marks the last
// result of the image. The rate is set by the per-column running-maximum memory, which is read
// once when a pixel is accepted and written once when it leaves the input register; a write and
// a read of the same column in the same cycle are bypassed. A write to a size register restarts the
// frame at pixel (0,0). A configuration write must only be issued while the block is idle.
module max_pooling_2d_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WINDOW = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [15:0]                          s_axis_tdata,  // [15:0] pixel
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [31:0]                          m_axis_tdata,  // [15:0] pooled_max,
                                                              // [23:16] out_row, [31:24] out_col
  output logic                                 m_axis_tlast,  // frame_end
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mp2d_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import mp2d_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [IMG_SIZE_BITS-1:0] image_width, image_height;
  logic [WIN_SIZE_BITS-1:0] window_rows, window_cols;
  logic [IMG_SIZE_BITS-1:0] eff_width, eff_height;
  logic [WIN_SIZE_BITS-1:0] eff_rows, eff_cols;
  logic                     cfg_write, cfg_hit;

  pos_info_t               pos_info;
  logic [CW-1:0]           pos_slot;

  logic                    s0_valid;
  logic signed [15:0]      s0_pixel;
  pos_info_t               s0_info;
  logic [CW-1:0]           s0_slot;
  logic signed [15:0]      rd_data;
  logic signed [15:0]      s0_max;
  logic                    s0_move, accept, out_free;

  logic signed [15:0]      col_max [MAX_WIDTH];

  // Configuration
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    unique case (cfg_index) inside
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_WINDOW_ROWS, REG_WINDOW_COLS: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_IMAGE_WIDTH;
      image_height <= RESET_IMAGE_HEIGHT;
      window_rows  <= RESET_WINDOW_ROWS;
      window_cols  <= RESET_WINDOW_COLS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_WINDOW_ROWS:  window_rows  <= cfg_data[WIN_SIZE_BITS-1:0];
        REG_WINDOW_COLS:  window_cols  <= cfg_data[WIN_SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign eff_width  = clamp_size(image_width, MAX_WIDTH);
  assign eff_height = clamp_size(image_height, MAX_HEIGHT);
  assign eff_rows   = WIN_SIZE_BITS'(clamp_size(IMG_SIZE_BITS'(window_rows), MAX_WINDOW));
  assign eff_cols   = WIN_SIZE_BITS'(clamp_size(IMG_SIZE_BITS'(window_cols), MAX_WINDOW));

  // Handshake
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s0_move       = s0_valid && (!s0_info.emit || out_free);
  assign s_axis_tready = !s0_valid || s0_move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mp2d_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_pos (
    .clk      (clk),
    .rst      (rst),
    .restart  (cfg_write && cfg_hit),
    .advance  (accept),
    .width    (eff_width),
    .height   (eff_height),
    .win_rows (eff_rows),
    .win_cols (eff_cols),
    .info     (pos_info),
    .slot     (pos_slot)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (accept) begin
      s0_valid <= 1'b1;
    end else if (s0_move) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_pixel <= s_axis_tdata;
      s0_info  <= pos_info;
      s0_slot  <= pos_slot;
    end
  end

  assign s0_max = (s0_info.first || (s0_pixel > rd_data)) ? s0_pixel : rd_data;

  // Running maximum per output column; same-column write bypasses the read
  always_ff @(posedge clk) begin
    if (s0_move) begin
      col_max[s0_slot] <= s0_max;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (s0_move && (s0_slot == pos_slot)) begin
        rd_data <= s0_max;
      end else begin
        rd_data <= col_max[pos_slot];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s0_move && s0_info.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_move && s0_info.emit) begin
      m_axis_tdata <= {s0_info.out_col, s0_info.out_row, s0_max};
      m_axis_tlast <= s0_info.frame_end;
    end
  end

endmodule

FILE: rtl/core/mp2d_checker.sv
// Port-level checks for the max pooling block, bound to the top level.
module mp2d_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A fresh result is preceded by a pixel transaction
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a pixel transaction");

  // With the output empty the input is never held off
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind max_pooling_2d_top mp2d_checker u_mp2d_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: sim/max_pooling_2d_checker.sv
// Scoreboard for the 2-D max pooling block: predicts every pooled result and compares it.
`timescale 1ns / 100ps

module max_pooling_2d_checker #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WINDOW = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,  // [15:0] pixel
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [31:0]                         m_axis_tdata,  // [15:0] pooled_max,
                                                             // [23:16] out_row, [31:24] out_col
  input  logic                                m_axis_tlast,  // frame_end
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [mp2d_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  pending
);
  import mp2d_pkg::*;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] peak;
    logic [INDEX_BITS-1:0]        row;
    logic [INDEX_BITS-1:0]        col;
    logic                         last;
  } pool_result_t;

  localparam int REPORT_LIMIT = 200;

  pool_result_t pooled_expected[$];

  logic [IMG_SIZE_BITS-1:0] cfg_width, cfg_height;
  logic [WIN_SIZE_BITS-1:0] cfg_win_rows, cfg_win_cols;

  // next pixel position, position inside its window, and the window's output position
  logic [INDEX_BITS-1:0]        x_pos, y_pos, out_x, out_y;
  logic [3:0]                   band_row, win_col;
  logic signed [PIXEL_BITS-1:0] col_peak [MAX_WIDTH];

  // zero counts as one, oversize counts as the maximum
  function automatic int limit_size(int v, int hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic void rewind_position();
    x_pos    = '0;
    y_pos    = '0;
    out_x    = '0;
    out_y    = '0;
    band_row = '0;
    win_col  = '0;
  endfunction

  always @(posedge clk) begin : track
    int ew, eh, ewr, ewc;
    logic signed [PIXEL_BITS-1:0] px;
    logic last_col, last_row;
    pool_result_t want, got;
    if (rst) begin
      cfg_width    = RESET_IMAGE_WIDTH;
      cfg_height   = RESET_IMAGE_HEIGHT;
      cfg_win_rows = RESET_WINDOW_ROWS;
      cfg_win_cols = RESET_WINDOW_COLS;
      rewind_position();
      pooled_expected.delete();
      fail_count = 0;
    end else begin
      // results first, so a result never meets an expectation queued at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.peak = m_axis_tdata[15:0];
        got.row  = m_axis_tdata[23:16];
        got.col  = m_axis_tdata[31:24];
        got.last = m_axis_tlast;
        if (pooled_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: unexpected result: max %0d row %0d col %0d last %0b",
                     $time, $signed(got.peak), got.row, got.col, got.last);
        end else begin
          want = pooled_expected.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display({"%0t: result mismatch: expected max %0d row %0d col %0d last %0b, ",
                        "actual max %0d row %0d col %0d last %0b"},
                       $time, $signed(want.peak), want.row, want.col, want.last,
                       $signed(got.peak), got.row, got.col, got.last);
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            cfg_width = cfg_data;
            rewind_position();
          end
          REG_IMAGE_HEIGHT: begin
            cfg_height = cfg_data;
            rewind_position();
          end
          REG_WINDOW_ROWS: begin
            cfg_win_rows = cfg_data[WIN_SIZE_BITS-1:0];
            rewind_position();
          end
          REG_WINDOW_COLS: begin
            cfg_win_cols = cfg_data[WIN_SIZE_BITS-1:0];
            rewind_position();
          end
          default: ;  // unused index, frame position kept
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        ew  = limit_size(int'(cfg_width), MAX_WIDTH);
        eh  = limit_size(int'(cfg_height), MAX_HEIGHT);
        ewr = limit_size(int'(cfg_win_rows), MAX_WINDOW);
        ewc = limit_size(int'(cfg_win_cols), MAX_WINDOW);
        px  = s_axis_tdata;
        last_col = int'(x_pos) >= ew - 1;
        last_row = int'(y_pos) >= eh - 1;

        if (band_row == '0 && win_col == '0)
          col_peak[out_x] = px;
        else if (px > col_peak[out_x])
          col_peak[out_x] = px;

        // clipped windows close at the right and bottom image edges
        if ((last_col || int'(win_col) >= ewc - 1) && (last_row || int'(band_row) >= ewr - 1)) begin
          want.peak = col_peak[out_x];
          want.row  = out_y;
          want.col  = out_x;
          want.last = last_col && last_row;
          pooled_expected.push_back(want);
        end

        if (last_col) begin
          x_pos   = '0;
          win_col = '0;
          out_x   = '0;
          if (last_row) begin
            rewind_position();
          end else begin
            y_pos++;
            if (int'(band_row) >= ewr - 1) begin
              band_row = '0;
              out_y++;
            end else begin
              band_row++;
            end
          end
        end else begin
          x_pos++;
          if (int'(win_col) >= ewc - 1) begin
            win_col = '0;
            out_x++;
          end else begin
            win_col++;
          end
        end
      end
    end
    pending <= pooled_expected.size();
  end

endmodule

FILE: sim/max_pooling_2d_top_tb.sv
// Testbench top for the 2-D max pooling block: pixel and register stimulus, and the verdict.
`timescale 1ns / 100ps

module max_pooling_2d_top_tb;
  import mp2d_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int TOTAL_ITEMS   = 850;
  localparam int QUIET_ITEMS   = 150;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_LOW  = 4'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_HIGH = 4'd15;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [15:0]               s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [31:0]               m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int items_sent  = 0;
  bit idle_on     = 1'b1;
  int hold_req    = 0;
  int hold_served = 0;

  max_pooling_2d_top dut (.*);

  max_pooling_2d_checker scoreboard (.*);

  always #10 clk = ~clk;

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(0, 31)) - 16'd16;  // close to zero, both signs
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [15:0] value);
    if (idle_on && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // valid stays up across back-to-back writes when more follow
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic set_sizes(input logic [CFG_DATA_BITS-1:0] w, input logic [CFG_DATA_BITS-1:0] h,
                           input logic [CFG_DATA_BITS-1:0] wr,
                           input logic [CFG_DATA_BITS-1:0] wc);
    write_reg(REG_IMAGE_WIDTH, w, 1'b1);
    write_reg(REG_IMAGE_HEIGHT, h, 1'b1);
    write_reg(REG_WINDOW_ROWS, wr, 1'b1);
    write_reg(REG_WINDOW_COLS, wc, 1'b0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // a trailing pixel may still be in the pipe with no result owed
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    @(posedge clk);
    forever begin
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] first_frame [25];
    int w, h, wr, wc, ew, eh, n;
    // 5x5 image in 3x3 windows: two clipped windows on the right, two at the bottom
    first_frame = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h8000,
                    16'h0001, 16'h5555, 16'hAAAA, 16'h8001, 16'h8000,
                    16'hFFFE, 16'h0000, 16'h8000, 16'h8000, 16'h8002,
                    16'h7FFF, 16'h8000, 16'h0001, 16'h8000, 16'h8000,
                    16'h1234, 16'hEDCB, 16'h7FFE, 16'h8000, 16'h8000};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (first_frame[i]) send_pixel(first_frame[i]);
    settle();

    // zero sizes read as one: every pixel is a whole frame
    set_sizes(9'd0, 9'd0, 9'd0, 9'd0);
    repeat (20) send_pixel(rand_pixel());
    settle();

    // one result per pixel while the sink holds off, so the input has to stall
    set_sizes(9'd4, 9'd3, 9'd1, 9'd1);
    hold_req++;
    repeat (100) send_pixel(rand_pixel());
    drain();
    repeat (30) send_pixel(rand_pixel());
    settle();

    // widest image, window rows above the limit, output column up to 255
    set_sizes(9'h1FF, 9'd1, 9'd31, 9'd1);
    repeat (256) send_pixel(rand_pixel());
    settle();

    // tallest image, output row up to 255; upper data bits of a window write are dropped
    set_sizes(9'd1, 9'd256, 9'd1, 9'h1E1);
    repeat (256) send_pixel(rand_pixel());
    settle();

    // full 16x16 window clipped to two columns
    set_sizes(9'd2, 9'd17, 9'd16, 9'd16);
    repeat (34) send_pixel(rand_pixel());
    settle();

    // unused indexes in the middle of a frame must not restart it
    set_sizes(9'd7, 9'd5, 9'd2, 9'd3);
    repeat (20) send_pixel(rand_pixel());
    settle();
    write_reg(REG_UNUSED_LOW, 9'h0AA, 1'b1);
    write_reg(REG_UNUSED_HIGH, 9'h155, 1'b0);
    repeat (15) send_pixel(rand_pixel());
    settle();

    while (items_sent < TOTAL_ITEMS) begin
      idle_on = (items_sent < TOTAL_ITEMS - QUIET_ITEMS) && ($urandom_range(3) != 0);
      if ($urandom_range(4) == 0) begin
        write_reg($urandom_range(1) ? REG_UNUSED_LOW : REG_UNUSED_HIGH,
                  CFG_DATA_BITS'($urandom), 1'b0);
        n = $urandom_range(1, 40);
      end else begin
        case ($urandom_range(9))
          0:       w = 0;
          1:       w = $urandom_range(257, 511);
          2:       w = 256;
          default: w = $urandom_range(1, 24);
        endcase
        case ($urandom_range(9))
          0:       h = 0;
          1:       h = $urandom_range(257, 511);
          default: h = $urandom_range(1, 12);
        endcase
        case ($urandom_range(7))
          0:       wr = 0;
          1:       wr = $urandom_range(16, 31);
          2:       wr = $urandom_range(0, 511);
          default: wr = $urandom_range(1, 5);
        endcase
        case ($urandom_range(7))
          0:       wc = 0;
          1:       wc = $urandom_range(16, 31);
          2:       wc = $urandom_range(0, 511);
          default: wc = $urandom_range(1, 5);
        endcase
        set_sizes(CFG_DATA_BITS'(w), CFG_DATA_BITS'(h), CFG_DATA_BITS'(wr),
                  CFG_DATA_BITS'(wc));
        ew = (w == 0) ? 1 : ((w > 256) ? 256 : w);
        eh = (h == 0) ? 1 : ((h > 256) ? 256 : h);
        if (ew * eh <= 160 && $urandom_range(1) == 1)
          n = ew * eh * $urandom_range(1, 2);
        else
          n = $urandom_range(1, 80);
      end
      if (n > TOTAL_ITEMS - items_sent) n = TOTAL_ITEMS - items_sent;
      repeat (n) send_pixel(rand_pixel());
      settle();
    end

    if (fail_count == 0) begin
      $display("max_pooling_2d_top test passed");
    end else begin
      $display("max_pooling_2d_top test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("max_pooling_2d_top test failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/mp2d_pkg.sv
rtl/core/mp2d_pos.sv
rtl/core/max_pooling_2d_top.sv
rtl/core/mp2d_checker.sv
sim/max_pooling_2d_checker.sv
sim/max_pooling_2d_top_tb.sv
